### design/sip_pkg.sv
package sip_pkg;

  typedef enum logic [1:0] {
    ST_NONE     = 2'd0,
    ST_HIT      = 2'd1,
    ST_PARALLEL = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [31:0] a_start_x;
    logic signed [31:0] a_start_y;
    logic signed [31:0] a_end_x;
    logic signed [31:0] a_end_y;
    logic signed [31:0] b_start_x;
    logic signed [31:0] b_start_y;
    logic signed [31:0] b_end_x;
    logic signed [31:0] b_end_y;
  } item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] cross_x;
    logic signed [31:0] cross_y;
  } result_t;

  // Control that travels alongside the arithmetic.
  typedef struct packed {
    logic    valid;
    status_e status;
  } ctl_t;

  localparam int unsigned ThrWidth = 63;

endpackage

### design/sip_geom.sv
module sip_geom #(
  parameter int unsigned W = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  sip_pkg::item_t           item_i,
  input  logic [sip_pkg::ThrWidth-1:0] thr_i,
  output sip_pkg::ctl_t            ctl_o,
  output logic [3*W+2:0]           numx_o,
  output logic [3*W+2:0]           numy_o,
  output logic                     negx_o,
  output logic                     negy_o,
  output logic [2*W+2:0]           den_o
);
  import sip_pkg::*;

  localparam int unsigned NW = 3 * W + 3;
  localparam int unsigned DW = 2 * W + 3;
  localparam int unsigned CW = (DW > ThrWidth) ? DW : ThrWidth;

  // Stage 0: coordinates, low W bits taken as signed.
  logic v0_q;
  logic signed [W-1:0] a1x_q, a1y_q, a2x_q, a2y_q, b1x_q, b1y_q, b2x_q, b2y_q;

  // Stage 1: difference vectors and copies of the endpoints.
  logic v1_q;
  logic signed [W:0] vxa_q, vya_q, ubx_q, uby_q, lbx_q, lby_q;
  logic signed [W:0] vxb_q, vyb_q, p1x_q, p1y_q, p2x_q, p2y_q;
  logic signed [W-1:0] c1x_q, c1y_q, c2x_q, c2y_q, c3x_q, c3y_q, c4x_q, c4y_q;

  // Stage 2: products.
  logic v2_q;
  logic signed [2*W+1:0] ca1_q, ca2_q, ca3_q, ca4_q, cb1_q, cb2_q, cb3_q, cb4_q;
  logic signed [2*W+1:0] d1_q, d2_q;
  logic signed [2*W-1:0] e1_q, e2_q, f1_q, f2_q;
  logic signed [W:0] vxa2_q, vya2_q, vxb2_q, vyb2_q;

  // Stage 3: cross products, determinant and endpoint determinants.
  logic v3_q;
  logic signed [2*W+2:0] xa1_q, xa2_q, xb1_q, xb2_q, den_q;
  logic signed [2*W:0]   dxya_q, dxyb_q;
  logic signed [W:0] vxa3_q, vya3_q, vxb3_q, vyb3_q;

  // Stage 4: straddle test, determinant magnitude, numerator partial products.
  logic v4_q, hit_q, dneg4_q;
  logic [DW-1:0] dm4_q;
  logic signed [2*W+1:0] pxbh_q, pxah_q, pxbl_q, pxal_q;
  logic signed [2*W+1:0] pybh_q, pyah_q, pybl_q, pyal_q;

  // Stage 5: status and full numerators.
  ctl_t ctl5_q;
  logic dneg5_q;
  logic [DW-1:0] dm5_q;
  logic signed [NW-1:0] numx_q, numy_q;

  // Stage 6: magnitudes and quotient signs.
  ctl_t ctl6_q;
  logic [DW-1:0] dm6_q;
  logic [NW-1:0] mx_q, my_q;
  logic nx_q, ny_q;

  logic hit_d;
  logic signed [W:0] loa, lob, hia, hib;
  status_e st_d;

  assign hit_d = (xa1_q == '0 || xa2_q == '0 || xa1_q[2*W+2] != xa2_q[2*W+2])
              && (xb1_q == '0 || xb2_q == '0 || xb1_q[2*W+2] != xb2_q[2*W+2]);

  assign loa = $signed({1'b0, dxya_q[W-1:0]});
  assign lob = $signed({1'b0, dxyb_q[W-1:0]});
  assign hia = $signed(dxya_q[2*W:W]);
  assign hib = $signed(dxyb_q[2*W:W]);

  always_comb begin
    if (!hit_q) begin
      st_d = ST_NONE;
    end else if (dm4_q == '0 || CW'(dm4_q) < CW'(thr_i)) begin
      st_d = ST_PARALLEL;
    end else begin
      st_d = ST_HIT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q   <= 1'b0;
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      v4_q   <= 1'b0;
      ctl5_q <= '{valid: 1'b0, status: ST_NONE};
      ctl6_q <= '{valid: 1'b0, status: ST_NONE};
    end else begin
      v0_q   <= valid_i;
      v1_q   <= v0_q;
      v2_q   <= v1_q;
      v3_q   <= v2_q;
      v4_q   <= v3_q;
      ctl5_q <= '{valid: v4_q, status: st_d};
      ctl6_q <= ctl5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a1x_q <= item_i.a_start_x[W-1:0];
    a1y_q <= item_i.a_start_y[W-1:0];
    a2x_q <= item_i.a_end_x[W-1:0];
    a2y_q <= item_i.a_end_y[W-1:0];
    b1x_q <= item_i.b_start_x[W-1:0];
    b1y_q <= item_i.b_start_y[W-1:0];
    b2x_q <= item_i.b_end_x[W-1:0];
    b2y_q <= item_i.b_end_y[W-1:0];

    vxa_q <= (W+1)'(a2x_q) - (W+1)'(a1x_q);
    vya_q <= (W+1)'(a2y_q) - (W+1)'(a1y_q);
    ubx_q <= (W+1)'(b2x_q) - (W+1)'(a1x_q);
    uby_q <= (W+1)'(b2y_q) - (W+1)'(a1y_q);
    lbx_q <= (W+1)'(b1x_q) - (W+1)'(a1x_q);
    lby_q <= (W+1)'(b1y_q) - (W+1)'(a1y_q);
    vxb_q <= (W+1)'(b2x_q) - (W+1)'(b1x_q);
    vyb_q <= (W+1)'(b2y_q) - (W+1)'(b1y_q);
    p1x_q <= (W+1)'(a1x_q) - (W+1)'(b1x_q);
    p1y_q <= (W+1)'(a1y_q) - (W+1)'(b1y_q);
    p2x_q <= (W+1)'(a2x_q) - (W+1)'(b1x_q);
    p2y_q <= (W+1)'(a2y_q) - (W+1)'(b1y_q);
    c1x_q <= a1x_q;
    c1y_q <= a1y_q;
    c2x_q <= a2x_q;
    c2y_q <= a2y_q;
    c3x_q <= b1x_q;
    c3y_q <= b1y_q;
    c4x_q <= b2x_q;
    c4y_q <= b2y_q;

    ca1_q <= (2*W+2)'(vxa_q) * (2*W+2)'(uby_q);
    ca2_q <= (2*W+2)'(ubx_q) * (2*W+2)'(vya_q);
    ca3_q <= (2*W+2)'(vxa_q) * (2*W+2)'(lby_q);
    ca4_q <= (2*W+2)'(lbx_q) * (2*W+2)'(vya_q);
    cb1_q <= (2*W+2)'(vxb_q) * (2*W+2)'(p1y_q);
    cb2_q <= (2*W+2)'(p1x_q) * (2*W+2)'(vyb_q);
    cb3_q <= (2*W+2)'(vxb_q) * (2*W+2)'(p2y_q);
    cb4_q <= (2*W+2)'(p2x_q) * (2*W+2)'(vyb_q);
    d1_q  <= (2*W+2)'(vxa_q) * (2*W+2)'(vyb_q);
    d2_q  <= (2*W+2)'(vya_q) * (2*W+2)'(vxb_q);
    e1_q  <= (2*W)'(c1x_q) * (2*W)'(c2y_q);
    e2_q  <= (2*W)'(c1y_q) * (2*W)'(c2x_q);
    f1_q  <= (2*W)'(c3x_q) * (2*W)'(c4y_q);
    f2_q  <= (2*W)'(c3y_q) * (2*W)'(c4x_q);
    vxa2_q <= vxa_q;
    vya2_q <= vya_q;
    vxb2_q <= vxb_q;
    vyb2_q <= vyb_q;

    xa1_q  <= (2*W+3)'(ca1_q) - (2*W+3)'(ca2_q);
    xa2_q  <= (2*W+3)'(ca3_q) - (2*W+3)'(ca4_q);
    xb1_q  <= (2*W+3)'(cb1_q) - (2*W+3)'(cb2_q);
    xb2_q  <= (2*W+3)'(cb3_q) - (2*W+3)'(cb4_q);
    den_q  <= (2*W+3)'(d1_q) - (2*W+3)'(d2_q);
    dxya_q <= (2*W+1)'(e1_q) - (2*W+1)'(e2_q);
    dxyb_q <= (2*W+1)'(f1_q) - (2*W+1)'(f2_q);
    vxa3_q <= vxa2_q;
    vya3_q <= vya2_q;
    vxb3_q <= vxb2_q;
    vyb3_q <= vyb2_q;

    hit_q   <= hit_d;
    dneg4_q <= den_q[2*W+2];
    dm4_q   <= den_q[2*W+2] ? DW'(-den_q) : DW'(den_q);
    pxbh_q  <= (2*W+2)'(vxa3_q) * (2*W+2)'(hib);
    pxah_q  <= (2*W+2)'(vxb3_q) * (2*W+2)'(hia);
    pxbl_q  <= (2*W+2)'(vxa3_q) * (2*W+2)'(lob);
    pxal_q  <= (2*W+2)'(vxb3_q) * (2*W+2)'(loa);
    pybh_q  <= (2*W+2)'(vya3_q) * (2*W+2)'(hib);
    pyah_q  <= (2*W+2)'(vyb3_q) * (2*W+2)'(hia);
    pybl_q  <= (2*W+2)'(vya3_q) * (2*W+2)'(lob);
    pyal_q  <= (2*W+2)'(vyb3_q) * (2*W+2)'(loa);

    // The endpoint determinants were split into a high signed part and a low
    // unsigned part of W bits; the high products weigh 2^W.
    dneg5_q <= dneg4_q;
    dm5_q   <= dm4_q;
    numx_q  <= ((NW'(pxbh_q) - NW'(pxah_q)) <<< W) + NW'(pxbl_q) - NW'(pxal_q);
    numy_q  <= ((NW'(pybh_q) - NW'(pyah_q)) <<< W) + NW'(pybl_q) - NW'(pyal_q);

    dm6_q <= dm5_q;
    mx_q  <= numx_q[NW-1] ? NW'(-numx_q) : NW'(numx_q);
    my_q  <= numy_q[NW-1] ? NW'(-numy_q) : NW'(numy_q);
    nx_q  <= numx_q[NW-1] ^ dneg5_q;
    ny_q  <= numy_q[NW-1] ^ dneg5_q;
  end

  assign ctl_o  = ctl6_q;
  assign numx_o = mx_q;
  assign numy_o = my_q;
  assign negx_o = nx_q;
  assign negy_o = ny_q;
  assign den_o  = dm6_q;

endmodule

### design/sip_div.sv
module sip_div #(
  parameter int unsigned W = 32
) (
  input  logic           clk_i,
  input  logic [3*W+2:0] n_i,
  input  logic [2*W+2:0] d_i,
  input  logic           neg_i,
  output logic [W-1:0]   q_o,
  output logic           ovf_o,
  output logic           neg_o
);

  localparam int unsigned NW = 3 * W + 3;
  localparam int unsigned DW = 2 * W + 3;

  // Entry j holds the state before quotient bit W-1-j is decided.
  logic [NW-1:0] r_q   [0:W-1];
  logic [DW-1:0] d_q   [0:W-1];
  logic [W-1:0]  q_q   [0:W];
  logic          ovf_q [0:W];
  logic          neg_q [0:W];

  // A quotient of 2^W or more saturates anyway, so only W bits are developed.
  always_ff @(posedge clk_i) begin
    r_q[0]   <= n_i;
    d_q[0]   <= d_i;
    q_q[0]   <= '0;
    ovf_q[0] <= n_i >= (NW'(d_i) << W);
    neg_q[0] <= neg_i;
  end

  for (genvar j = 0; j < W; j++) begin : g_step
    logic [NW-1:0] sub;
    logic          take;
    assign sub  = NW'(d_q[j]) << (W - 1 - j);
    assign take = r_q[j] >= sub;

    always_ff @(posedge clk_i) begin
      q_q[j+1]   <= {q_q[j][W-2:0], take};
      ovf_q[j+1] <= ovf_q[j];
      neg_q[j+1] <= neg_q[j];
    end

    if (j < W - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        r_q[j+1] <= take ? r_q[j] - sub : r_q[j];
        d_q[j+1] <= d_q[j];
      end
    end
  end

  assign q_o   = q_q[W];
  assign ovf_o = ovf_q[W];
  assign neg_o = neg_q[W];

endmodule

### design/segment_intersection_point_top.sv
// Two-segment intersection in signed fixed point. One item enters per clock on
// start_i; busy_o never rises, so an item may be given in every cycle. Each
// item yields exactly one result beat, marked by result_valid_o for a single
// cycle. It passes through seven stages of capture, products, sums and
// magnitudes, a divider input stage, a restoring divider that develops one
// quotient bit per stage, and an output register. The receiver cannot stall
// and must take every result as it appears. status is 0 when the segments do
// not cross, 2 when they cross but the determinant magnitude is below the
// configured threshold (always for collinear or degenerate segments) and 1
// with the point in cross_x and cross_y, which are zero otherwise. The
// threshold is written through the cfg channel, which is always ready, and
// should only change with the pipeline empty.
module segment_intersection_point_top #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  sip_pkg::item_t                item_i,
  output logic                          result_valid_o,
  output sip_pkg::result_t              result_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [sip_pkg::ThrWidth-1:0]  cfg_data_i
);
  import sip_pkg::*;

  localparam int unsigned W  = COORD_WIDTH;
  localparam int unsigned NW = 3 * W + 3;
  localparam int unsigned DW = 2 * W + 3;

  logic [ThrWidth-1:0] thr_q;
  ctl_t                gctl;
  logic [NW-1:0]       numx, numy;
  logic [DW-1:0]       den;
  logic                negx, negy, ovfx, ovfy, qnx, qny;
  logic [W-1:0]        qx, qy;
  ctl_t                ctl_q [0:W];
  logic                rvalid_q;
  result_t             res_q;

  function automatic logic signed [31:0] finish(input logic [W-1:0] q, input logic ovf,
                                                 input logic neg);
    logic [W-1:0] lim;
    logic [W-1:0] sat;
    logic [W-1:0] val;
    lim = {1'b0, {(W-1){1'b1}}} + W'(neg);
    sat = (ovf || q > lim) ? lim : q;
    val = neg ? W'(-sat) : sat;
    return 32'($signed(val));
  endfunction

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ThrWidth'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      thr_q <= cfg_data_i;
    end
  end

  sip_geom #(.W(W)) u_geom (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start_i && !busy_o),
    .item_i  (item_i),
    .thr_i   (thr_q),
    .ctl_o   (gctl),
    .numx_o  (numx),
    .numy_o  (numy),
    .negx_o  (negx),
    .negy_o  (negy),
    .den_o   (den)
  );

  sip_div #(.W(W)) u_div_x (
    .clk_i (clk_i),
    .n_i   (numx),
    .d_i   (den),
    .neg_i (negx),
    .q_o   (qx),
    .ovf_o (ovfx),
    .neg_o (qnx)
  );

  sip_div #(.W(W)) u_div_y (
    .clk_i (clk_i),
    .n_i   (numy),
    .d_i   (den),
    .neg_i (negy),
    .q_o   (qy),
    .ovf_o (ovfy),
    .neg_o (qny)
  );

  // Status and valid follow the divider stage by stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= W; i++) begin
        ctl_q[i] <= '{valid: 1'b0, status: ST_NONE};
      end
      rvalid_q <= 1'b0;
    end else begin
      ctl_q[0] <= gctl;
      for (int i = 1; i <= W; i++) begin
        ctl_q[i] <= ctl_q[i-1];
      end
      rvalid_q <= ctl_q[W].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q.status <= ctl_q[W].status;
    if (ctl_q[W].status == ST_HIT) begin
      res_q.cross_x <= finish(qx, ovfx, qnx);
      res_q.cross_y <= finish(qy, ovfy, qny);
    end else begin
      res_q.cross_x <= '0;
      res_q.cross_y <= '0;
    end
  end

  assign result_valid_o = rvalid_q;
  assign result_o       = res_q;

`ifndef SYNTHESIS
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (result_o.status == ST_NONE || result_o.status == ST_HIT
                        || result_o.status == ST_PARALLEL))
    else $error("result status code out of range");

  a_point_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.status != ST_HIT)
      |-> (result_o.cross_x == '0 && result_o.cross_y == '0))
    else $error("point reported without a crossing");

  a_ctl_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_q[W].valid |=> result_valid_o)
    else $error("result beat lost at the output stage");
`endif

endmodule

### dv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sip_pkg::*;

  localparam int unsigned Latency = 41;
  localparam int unsigned IdleLimit = 4000;
  localparam int unsigned NumRandom = 700;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  item_t               item;
  logic                res_valid;
  result_t             res;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [ThrWidth-1:0] cfg_data;

  segment_intersection_point_top u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start_i        (start),
    .busy_o         (busy),
    .item_i         (item),
    .result_valid_o (res_valid),
    .result_o       (res),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_data_i     (cfg_data)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  logic [ThrWidth-1:0] thr_model;
  result_t             pending_points[$];
  int                  error_count;
  int                  idle_cycles;
  int                  beats_in;
  int                  beats_out;
  int                  hit_count;
  int                  par_count;

  typedef struct {
    item_t   pair;
    logic    known;
    result_t want;
  } vector_t;

  vector_t vectors[$];

  function automatic logic signed [127:0] sx(input logic signed [31:0] v);
    return 128'(v);
  endfunction

  function automatic logic signed [127:0] cross_prod(
    input logic signed [127:0] vx, input logic signed [127:0] vy,
    input logic signed [127:0] wx, input logic signed [127:0] wy);
    return vx * wy - wx * vy;
  endfunction

  function automatic logic straddles(input logic signed [127:0] p,
                                     input logic signed [127:0] q);
    if (p == 0 || q == 0) return 1'b1;
    return p[127] != q[127];
  endfunction

  function automatic logic [31:0] sat_div(input logic signed [127:0] num,
                                          input logic signed [127:0] den);
    logic neg;
    logic [127:0] nm, dm, q, lim;
    neg = num[127] != den[127];
    nm = num[127] ? -num : num;
    dm = den[127] ? -den : den;
    q = nm / dm;
    lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
    if (q > lim) q = lim;
    return neg ? 32'(-q) : 32'(q);
  endfunction

  function automatic result_t predict_crossing(input item_t it);
    logic signed [127:0] ax1, ay1, ax2, ay2, bx1, by1, bx2, by2;
    logic signed [127:0] vx, vy, den, dm, dxa, dxb, dya, dyb, pa, pb;
    logic hit;
    result_t r;
    ax1 = sx(it.a_start_x); ay1 = sx(it.a_start_y);
    ax2 = sx(it.a_end_x);   ay2 = sx(it.a_end_y);
    bx1 = sx(it.b_start_x); by1 = sx(it.b_start_y);
    bx2 = sx(it.b_end_x);   by2 = sx(it.b_end_y);
    r = '0;
    vx = ax2 - ax1;
    vy = ay2 - ay1;
    hit = straddles(cross_prod(vx, vy, bx2 - ax1, by2 - ay1),
                    cross_prod(vx, vy, bx1 - ax1, by1 - ay1));
    if (hit) begin
      vx = bx2 - bx1;
      vy = by2 - by1;
      hit = straddles(cross_prod(vx, vy, ax1 - bx1, ay1 - by1),
                      cross_prod(vx, vy, ax2 - bx1, ay2 - by1));
    end
    if (!hit) begin
      r.status = ST_NONE;
      return r;
    end
    dxa = ax1 - ax2;
    dxb = bx1 - bx2;
    dya = ay1 - ay2;
    dyb = by1 - by2;
    den = dxa * dyb - dya * dxb;
    dm = den[127] ? -den : den;
    if (den == 0 || $unsigned(dm) < {65'd0, thr_model}) begin
      r.status = ST_PARALLEL;
      return r;
    end
    pa = ax1 * ay2 - ay1 * ax2;
    pb = bx1 * by2 - by1 * bx2;
    r.status = ST_HIT;
    r.cross_x = sat_div(pa * dxb - dxa * pb, den);
    r.cross_y = sat_div(pa * dyb - dya * pb, den);
    return r;
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'h7fff_ffff - $urandom_range(0, 3);
      2: return 32'h8000_0000 + $urandom_range(0, 3);
      default: return 32'($signed($urandom_range(0, 40 << 16)) - (20 << 16));
    endcase
  endfunction

  // Mostly pairs built around a common point, so that crossings are frequent.
  function automatic item_t rand_pair();
    item_t it;
    logic signed [31:0] px, py, dx, dy, ex, ey;
    if ($urandom_range(0, 4) == 0) begin
      it = {$urandom, $urandom, $urandom, $urandom,
            $urandom, $urandom, $urandom, $urandom};
      return it;
    end
    px = rand_coord() >>> $urandom_range(1, 8);
    py = rand_coord() >>> $urandom_range(1, 8);
    dx = $signed($urandom) >>> $urandom_range(2, 30);
    dy = $signed($urandom) >>> $urandom_range(2, 30);
    ex = $signed($urandom) >>> $urandom_range(2, 30);
    ey = $signed($urandom) >>> $urandom_range(2, 30);
    if ($urandom_range(0, 9) == 0) begin
      ex = dx;
      ey = dy;
    end
    it.a_start_x = px - dx; it.a_start_y = py - dy;
    it.a_end_x   = px + dx; it.a_end_y   = py + dy;
    it.b_start_x = px - ex; it.b_start_y = py - ey;
    it.b_end_x   = px + ex; it.b_end_y   = py + ey;
    return it;
  endfunction

  function automatic vector_t mk_vec(input item_t it, input logic known,
                                     input result_t want);
    vector_t v;
    v.pair = it;
    v.known = known;
    v.want = want;
    return v;
  endfunction

  task automatic build_directed();
    localparam logic [31:0] One = 32'h0001_0000;
    localparam logic [31:0] Max = 32'h7fff_ffff;
    localparam logic [31:0] Min = 32'h8000_0000;
    result_t none, par, ctr;
    none = '{status: ST_NONE, cross_x: 0, cross_y: 0};
    par  = '{status: ST_PARALLEL, cross_x: 0, cross_y: 0};
    ctr  = '{status: ST_HIT, cross_x: 0, cross_y: 0};
    // An X through the origin.
    vectors.push_back(mk_vec({-One, -One, One, One, -One, One, One, -One}, 1, ctr));
    // Separate parallel horizontals.
    vectors.push_back(mk_vec({32'd0, 32'd0, One, 32'd0, 32'd0, One, One, One}, 1, none));
    // Collinear overlap, and both segments a single point.
    vectors.push_back(mk_vec({32'd0, 32'd0, One * 2, 32'd0, One, 32'd0, One * 3, 32'd0},
                             1, par));
    vectors.push_back(mk_vec({32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0},
                             1, par));
    vectors.push_back(mk_vec({Max, Max, Max, Max, Max, Max, Max, Max}, 1, par));
    vectors.push_back(mk_vec({Min, Min, Min, Min, Min, Min, Min, Min}, 1, par));
    // Full-range diagonals crossing near the origin.
    vectors.push_back(mk_vec({Min, Min, Max, Max, Min, Max, Max, Min}, 0, none));
    vectors.push_back(mk_vec({Max, Min, Min, Max, Min, Min, Max, Max}, 0, none));
    // Touching at an endpoint, a T junction, and further small and full-range crossings.
    vectors.push_back(mk_vec({32'd0, 32'd0, One, One, One, One, One * 2, 32'd0}, 0, none));
    vectors.push_back(mk_vec({-One, 32'd0, One, 32'd0, 32'd0, 32'd0, 32'd0, One}, 0, none));
    vectors.push_back(mk_vec({32'd3, 32'd0, -32'd3, 32'd1, -32'd1, -32'd1, 32'd1, 32'd2},
                             0, none));
    vectors.push_back(mk_vec({Min, 32'd0, Max, 32'd0, 32'd0, Min, 32'd0, Max}, 0, none));
    vectors.push_back(mk_vec({32'hffff_ffff, 32'd1, 32'd1, 32'hffff_ffff,
                              32'd0, 32'd0, 32'd1, 32'd1}, 0, none));
  endtask

  task automatic write_threshold(input logic [ThrWidth-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    thr_model = value;
  endtask

  task automatic drain();
    while (pending_points.size() != 0) @(posedge clk);
    repeat (Latency + 4) @(posedge clk);
  endtask

  // Sends one beat; a gap is only taken when the burst has run out.
  int burst_left;
  task automatic send_pair(input item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    start <= 1'b1;
    item  <= it;
    do @(posedge clk); while (busy);
    beats_in++;
    burst_left--;
    pending_points.push_back(predict_crossing(it));
  endtask

  task automatic check_known(input vector_t v);
    result_t p;
    p = predict_crossing(v.pair);
    if (v.known && p != v.want) begin
      $display("%0t: table entry disagrees with prediction: expected %p actual %p",
               $time, v.want, p);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst_n && res_valid) begin
      beats_out++;
      if (pending_points.size() == 0) begin
        $display("%0t: result beat with nothing pending: actual %p", $time, res);
        error_count++;
      end else begin
        want = pending_points.pop_front();
        if (res.status == ST_HIT) hit_count++;
        if (res.status == ST_PARALLEL) par_count++;
        if (res.status !== want.status)
          $display("%0t: status expected %0d actual %0d", $time, want.status, res.status);
        if (res.cross_x !== want.cross_x)
          $display("%0t: cross_x expected %h actual %h", $time, want.cross_x, res.cross_x);
        if (res.cross_y !== want.cross_y)
          $display("%0t: cross_y expected %h actual %h", $time, want.cross_y, res.cross_y);
        if (res !== want) error_count++;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || res_valid || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    logic [ThrWidth-1:0] thr_set[5];
    rst_n = 1'b0;
    start = 1'b0;
    item = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    thr_model = 1;
    error_count = 0;
    beats_in = 0;
    beats_out = 0;
    hit_count = 0;
    par_count = 0;
    burst_left = 0;
    build_directed();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (vectors[i]) begin
      check_known(vectors[i]);
      send_pair(vectors[i].pair);
    end
    start <= 1'b0;
    drain();
    // Threshold zero: only a zero determinant still counts as parallel.
    write_threshold('0);
    foreach (vectors[i]) send_pair(vectors[i].pair);
    start <= 1'b0;
    drain();

    thr_set = '{63'd1, 63'h7fff_ffff_ffff_ffff, 63'd1 << 40, 63'd1 << 20, 63'd0};
    foreach (thr_set[k]) begin
      write_threshold(k == 4 ? 63'({$urandom, $urandom}) >> $urandom_range(0, 40)
                             : thr_set[k]);
      repeat (NumRandom / 5) send_pair(rand_pair());
      start <= 1'b0;
      drain();
    end

    $display("Sent %0d segment pairs over %0d threshold settings; %0d beats returned.",
             beats_in, 7, beats_out);
    $display("Crossings with a point: %0d, near parallel: %0d.", hit_count, par_count);
    if (error_count == 0 && pending_points.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### files.f
design/sip_pkg.sv
design/sip_geom.sv
design/sip_div.sv
design/segment_intersection_point_top.sv
dv/testbench.sv
